// ===== hw/rtl/led_effect_color_renderer_macros.svh =====
// Assertion helpers for the LED color renderer.
// In simulation, each macro expands to a concurrent assertion on clock, disabled in reset; else it is empty.
`ifndef LED_EFFECT_COLOR_RENDERER_MACROS_SVH
`define LED_EFFECT_COLOR_RENDERER_MACROS_SVH
`ifndef SYNTHESIS
`define LECR_ASSERT_IMP(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error("lecr assertion failed");
`define LECR_ASSERT_NEXT(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error("lecr assertion failed");
`else
`define LECR_ASSERT_IMP(label, cond, expr)
`define LECR_ASSERT_NEXT(label, cond, expr)
`endif
`endif

// ===== hw/rtl/lecr_pkg.sv =====
`default_nettype none
package lecr_pkg;

   localparam int POSITION_COUNT = 128;
   localparam int TRAVEL_LIMIT   = 255;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   // reciprocals for exact floor division by constants
   localparam int RECIP_SHIFT = 26;
   localparam logic [31:0] POS_RECIP =
      32'((2**RECIP_SHIFT + POSITION_COUNT - 2) / (POSITION_COUNT - 1));
   localparam logic [31:0] TRAVEL_RECIP =
      32'((2**RECIP_SHIFT + TRAVEL_LIMIT - 1) / TRAVEL_LIMIT);
   localparam logic [31:0] DIV5_RECIP   = 32'hCCCC_CCCD;  // >> 34
   localparam logic [31:0] DIV255_RECIP = 32'd269488145;  // >> 36
   localparam logic [7:0]  TRAVEL_MAX   = 8'(TRAVEL_LIMIT);

   localparam logic [2:0] MODE_GRADIENT = 3'd1;
   localparam logic [2:0] MODE_AURORA   = 3'd2;
   localparam logic [2:0] MODE_REACTIVE = 3'd3;
   localparam logic [2:0] MODE_HEATMAP  = 3'd4;

   localparam logic [2:0] DIR_WEST   = 3'd1;
   localparam logic [2:0] DIR_SOUTH  = 3'd3;
   localparam logic [2:0] DIR_RADIAL = 3'd4;

   typedef enum logic [2:0] {
      CSR_LIGHTS,
      CSR_MODE,
      CSR_DIR,
      CSR_SPEED,
      CSR_PRIMARY,
      CSR_SECONDARY,
      CSR_REACTIVE
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WEIGHT,
      ST_SETW,
      ST_TIME,
      ST_DIV20,
      ST_PHASE,
      ST_DIV510,
      ST_TRI,
      ST_MIX_R,
      ST_MIX_G,
      ST_MIX_B,
      ST_FIN,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      OP_POS,
      OP_HEAT,
      OP_TIME,
      OP_DIV20,
      OP_DIV510,
      OP_MIX_R,
      OP_MIX_G,
      OP_MIX_B
   } mul_op_type;

   typedef enum logic [1:0] {
      KIND_FIXED,
      KIND_GRADIENT,
      KIND_AURORA,
      KIND_HEAT
   } kind_type;

   typedef struct packed {
      logic       idle;
      logic       heat;
      mul_op_type op;
      logic       ld_weight;
      logic       ld_phase;
      logic       ld_tri;
      logic       ld_red;
      logic       ld_green;
      logic       ld_blue;
      logic       done;
   } ctrl_type;

   // (s + 127) / 255 for s below 65026, shift-add form
   function automatic logic [7:0] div255_round(input logic [15:0] s);
      logic [16:0] x;
      logic [16:0] t;
      x = {1'b0, s} + 17'd127;
      t = x + 17'd1 + {8'd0, x[16:8]};
      return t[15:8];
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/lecr_if.sv =====
`default_nettype none
interface lecr_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic        first_key;
   logic [7:0]  key_travel;
   logic [6:0]  led_position;
   logic        led_present;
   logic [31:0] elapsed_ms;

   modport source (output valid, func, first_key, key_travel, led_position,
                   led_present, elapsed_ms, input ready);
   modport sink (input valid, func, first_key, key_travel, led_position,
                 led_present, elapsed_ms, output ready);
endinterface

interface lecr_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] out_position;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;

   modport source (output valid, out_position, red, green, blue, input ready);
   modport sink (input valid, out_position, red, green, blue, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/lecr_mul.sv =====
`default_nettype none
// shared 32x32 multiplier, product registered
module lecr_mul (
   input  wire logic        clock,
   input  wire logic [31:0] op_a,
   input  wire logic [31:0] op_b,
   output logic      [63:0] prod
);

   logic [63:0] prod_ff;
   logic [63:0] prod_in;

   assign prod_in = {32'd0, op_a} * {32'd0, op_b};

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/lecr_fsm.sv =====
`default_nettype none
module lecr_fsm (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire lecr_pkg::kind_type kind,
   input  wire logic               out_free,
   output lecr_pkg::ctrl_type      ctrl
);

   lecr_pkg::state_type state_ff;
   lecr_pkg::state_type state_in;
   lecr_pkg::kind_type  kind_ff;
   lecr_pkg::kind_type  kind_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lecr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      kind_ff <= kind_in;
   end

   assign kind_in = (state_ff == lecr_pkg::ST_IDLE && start) ? kind : kind_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lecr_pkg::ST_IDLE: begin
            if (start) begin
               state_in = (kind == lecr_pkg::KIND_FIXED) ? lecr_pkg::ST_DONE
                                                          : lecr_pkg::ST_WEIGHT;
            end
         end
         lecr_pkg::ST_WEIGHT: state_in = lecr_pkg::ST_SETW;
         lecr_pkg::ST_SETW: begin
            state_in = (kind_ff == lecr_pkg::KIND_AURORA) ? lecr_pkg::ST_TIME
                                                           : lecr_pkg::ST_MIX_R;
         end
         lecr_pkg::ST_TIME:   state_in = lecr_pkg::ST_DIV20;
         lecr_pkg::ST_DIV20:  state_in = lecr_pkg::ST_PHASE;
         lecr_pkg::ST_PHASE:  state_in = lecr_pkg::ST_DIV510;
         lecr_pkg::ST_DIV510: state_in = lecr_pkg::ST_TRI;
         lecr_pkg::ST_TRI:    state_in = lecr_pkg::ST_MIX_R;
         lecr_pkg::ST_MIX_R:  state_in = lecr_pkg::ST_MIX_G;
         lecr_pkg::ST_MIX_G:  state_in = lecr_pkg::ST_MIX_B;
         lecr_pkg::ST_MIX_B:  state_in = lecr_pkg::ST_FIN;
         lecr_pkg::ST_FIN:    state_in = lecr_pkg::ST_DONE;
         lecr_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = lecr_pkg::ST_IDLE;
            end
         end
         default: state_in = lecr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl      = '0;
      ctrl.op   = lecr_pkg::OP_POS;
      ctrl.heat = (kind_ff == lecr_pkg::KIND_HEAT);
      case (state_ff)
         lecr_pkg::ST_IDLE:   ctrl.idle = 1'b1;
         lecr_pkg::ST_WEIGHT: begin
            ctrl.op = (kind_ff == lecr_pkg::KIND_HEAT) ? lecr_pkg::OP_HEAT
                                                       : lecr_pkg::OP_POS;
         end
         lecr_pkg::ST_SETW:   ctrl.ld_weight = 1'b1;
         lecr_pkg::ST_TIME:   ctrl.op = lecr_pkg::OP_TIME;
         lecr_pkg::ST_DIV20:  ctrl.op = lecr_pkg::OP_DIV20;
         lecr_pkg::ST_PHASE:  ctrl.ld_phase = 1'b1;
         lecr_pkg::ST_DIV510: ctrl.op = lecr_pkg::OP_DIV510;
         lecr_pkg::ST_TRI:    ctrl.ld_tri = 1'b1;
         lecr_pkg::ST_MIX_R:  ctrl.op = lecr_pkg::OP_MIX_R;
         lecr_pkg::ST_MIX_G: begin
            ctrl.op     = lecr_pkg::OP_MIX_G;
            ctrl.ld_red = 1'b1;
         end
         lecr_pkg::ST_MIX_B: begin
            ctrl.op       = lecr_pkg::OP_MIX_B;
            ctrl.ld_green = 1'b1;
         end
         lecr_pkg::ST_FIN:    ctrl.ld_blue = 1'b1;
         lecr_pkg::ST_DONE:   ctrl.done = 1'b1;
         default:             ctrl.idle = 1'b0;
      endcase
   end

endmodule
`default_nettype wire

// ===== hw/rtl/led_effect_color_renderer.sv =====
`default_nettype none
// Channel    Dir  Handshake          Payload
// req_chan   in   valid/ready        func, first_key, key_travel, led_position,
//                                    led_present, elapsed_ms
// rsp_chan   out  valid/ready        out_position, red, green, blue
// csr_*      in   csr_we, no ready   csr_index, csr_wdata
//
// Travel request: never blocks. Render request, until ready again:
// off/absent/static/reactive go to done; gradient/heatmap: weight, mix steps;
// aurora adds phase steps. One shared 32x32 multiplier, one product a cycle.
// Reset is synchronous, active high; clears config, peak travel and control.
// A finished color waits in the output register; a new request is taken
// meanwhile, and the sequencer holds in its last state while rsp is stalled.
`include "led_effect_color_renderer_macros.svh"
module led_effect_color_renderer (
   input  wire logic                              clock,
   input  wire logic                              reset,
   lecr_req_if.sink                               req_chan,
   lecr_rsp_if.source                             rsp_chan,
   input  wire logic                              csr_we,
   input  wire logic [lecr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [lecr_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   // configuration
   logic        lights_ff;
   logic [2:0]  mode_ff;
   logic [2:0]  dir_ff;
   logic [7:0]  speed_ff;
   logic [23:0] primary_ff;
   logic [23:0] secondary_ff;
   logic [23:0] reactive_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lights_ff    <= 1'b0;
         mode_ff      <= '0;
         dir_ff       <= '0;
         speed_ff     <= '0;
         primary_ff   <= '0;
         secondary_ff <= '0;
         reactive_ff  <= '0;
      end else if (csr_we) begin
         case (lecr_pkg::csr_index_type'(csr_index))
            lecr_pkg::CSR_LIGHTS:    lights_ff    <= csr_wdata[0];
            lecr_pkg::CSR_MODE:      mode_ff      <= csr_wdata[2:0];
            lecr_pkg::CSR_DIR:       dir_ff       <= csr_wdata[2:0];
            lecr_pkg::CSR_SPEED:     speed_ff     <= csr_wdata[7:0];
            lecr_pkg::CSR_PRIMARY:   primary_ff   <= csr_wdata;
            lecr_pkg::CSR_SECONDARY: secondary_ff <= csr_wdata;
            lecr_pkg::CSR_REACTIVE:  reactive_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   lecr_pkg::ctrl_type ctrl;
   lecr_pkg::kind_type kind;
   logic               req_fire;
   logic               render_start;
   logic               out_free;
   logic               out_load;
   logic [63:0]        prod;

   assign req_chan.ready = ctrl.idle;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign render_start   = req_fire && req_chan.func;

   // peak travel
   logic [7:0] peak_ff;
   logic [7:0] peak_in;
   logic [7:0] travel_sat;

   assign travel_sat = (req_chan.key_travel > lecr_pkg::TRAVEL_MAX) ? lecr_pkg::TRAVEL_MAX
                                                                     : req_chan.key_travel;

   always_comb begin
      peak_in = peak_ff;
      if (req_fire && !req_chan.func && (req_chan.first_key || travel_sat > peak_ff)) begin
         peak_in = travel_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff <= '0;
      end else begin
         peak_ff <= peak_in;
      end
   end

   // what kind of work a render request needs
   logic [23:0] fixed_color;

   always_comb begin
      kind        = lecr_pkg::KIND_FIXED;
      fixed_color = primary_ff;
      if (!lights_ff || !req_chan.led_present) begin
         fixed_color = '0;
      end else begin
         case (mode_ff)
            lecr_pkg::MODE_GRADIENT: kind = lecr_pkg::KIND_GRADIENT;
            lecr_pkg::MODE_AURORA:   kind = lecr_pkg::KIND_AURORA;
            lecr_pkg::MODE_HEATMAP:  kind = lecr_pkg::KIND_HEAT;
            lecr_pkg::MODE_REACTIVE: begin
               fixed_color = (peak_ff == 8'd0) ? primary_ff : reactive_ff;
            end
            default: fixed_color = primary_ff;
         endcase
      end
   end

   lecr_fsm u_fsm (
      .clock    (clock),
      .reset    (reset),
      .start    (render_start),
      .kind     (kind),
      .out_free (out_free),
      .ctrl     (ctrl)
   );

   // working registers
   logic [6:0]  pos_ff;
   logic [31:0] ms_ff;
   logic [7:0]  w_ff;
   logic [28:0] phase_ff;
   logic [7:0]  red_ff;
   logic [7:0]  green_ff;
   logic [7:0]  blue_ff;

   // shared multiplier operands
   logic [14:0] pos_x255;
   logic [15:0] peak_x255;
   logic [23:0] color_b;
   logic [31:0] op_a;
   logic [31:0] op_b;
   logic [31:0] mix_b;

   assign pos_x255  = {pos_ff, 8'd0} - {8'd0, pos_ff};
   assign peak_x255 = {peak_ff, 8'd0} - {8'd0, peak_ff};
   assign color_b   = ctrl.heat ? reactive_ff : secondary_ff;
   // {w, 255-w}: the middle lane of the product is a*(255-w) + b*w
   assign mix_b     = {8'd0, w_ff, 8'd0, ~w_ff};

   always_comb begin
      op_a = '0;
      op_b = '0;
      case (ctrl.op)
         lecr_pkg::OP_POS: begin
            op_a = {17'd0, pos_x255};
            op_b = lecr_pkg::POS_RECIP;
         end
         lecr_pkg::OP_HEAT: begin
            op_a = {16'd0, peak_x255};
            op_b = lecr_pkg::TRAVEL_RECIP;
         end
         lecr_pkg::OP_TIME: begin
            op_a = ms_ff;
            op_b = {24'd0, speed_ff} + 32'd1;
         end
         lecr_pkg::OP_DIV20: begin
            op_a = {2'd0, prod[31:2]};
            op_b = lecr_pkg::DIV5_RECIP;
         end
         lecr_pkg::OP_DIV510: begin
            op_a = {4'd0, phase_ff[28:1]};
            op_b = lecr_pkg::DIV255_RECIP;
         end
         lecr_pkg::OP_MIX_R: begin
            op_a = {8'd0, primary_ff[23:16], 8'd0, color_b[23:16]};
            op_b = mix_b;
         end
         lecr_pkg::OP_MIX_G: begin
            op_a = {8'd0, primary_ff[15:8], 8'd0, color_b[15:8]};
            op_b = mix_b;
         end
         lecr_pkg::OP_MIX_B: begin
            op_a = {8'd0, primary_ff[7:0], 8'd0, color_b[7:0]};
            op_b = mix_b;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   lecr_mul u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   // weight from the reciprocal product, saturated, then direction rule (not for heatmap)
   logic [7:0]  n_sat;
   logic [7:0]  sweep_w;
   logic [20:0] qq;
   logic [29:0] qq_x510;
   logic [28:0] rem_full;
   logic [8:0]  rem;
   logic [8:0]  rem_back;
   logic [7:0]  tri_w;
   logic [7:0]  chan;

   assign n_sat = (|prod[63:34]) ? 8'hFF : prod[33:26];

   always_comb begin
      if (dir_ff == lecr_pkg::DIR_WEST || dir_ff == lecr_pkg::DIR_SOUTH) begin
         sweep_w = ~n_sat;
      end else if (dir_ff == lecr_pkg::DIR_RADIAL) begin
         sweep_w = {n_sat[7] ? ~n_sat[6:0] : n_sat[6:0], 1'b0};
      end else begin
         sweep_w = n_sat;
      end
   end

   // phase mod 510 = phase - 510 * ((phase >> 1) / 255)
   assign qq       = prod[56:36];
   assign qq_x510  = {qq, 9'd0} - {8'd0, qq, 1'b0};
   assign rem_full = phase_ff - qq_x510[28:0];
   assign rem      = rem_full[8:0];
   assign rem_back = 9'd510 - rem;
   assign tri_w    = rem[8] ? rem_back[7:0] : rem[7:0];

   assign chan = lecr_pkg::div255_round(prod[31:16]);

   always_ff @(posedge clock) begin
      if (render_start) begin
         pos_ff <= req_chan.led_position;
         ms_ff  <= req_chan.elapsed_ms;
      end
      if (ctrl.ld_weight) begin
         w_ff <= ctrl.heat ? n_sat : sweep_w;
      end else if (ctrl.ld_tri) begin
         w_ff <= tri_w;
      end
      if (ctrl.ld_phase) begin
         phase_ff <= {1'b0, prod[61:34]} + {20'd0, w_ff, 1'b0};
      end
      if (render_start) begin
         red_ff   <= fixed_color[23:16];
         green_ff <= fixed_color[15:8];
         blue_ff  <= fixed_color[7:0];
      end else begin
         if (ctrl.ld_red) begin
            red_ff <= chan;
         end
         if (ctrl.ld_green) begin
            green_ff <= chan;
         end
         if (ctrl.ld_blue) begin
            blue_ff <= chan;
         end
      end
   end

   // output register
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic [6:0] rsp_pos_ff;
   logic [7:0] rsp_red_ff;
   logic [7:0] rsp_green_ff;
   logic [7:0] rsp_blue_ff;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign out_load = ctrl.done && out_free;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (out_load) begin
         rsp_pos_ff   <= pos_ff;
         rsp_red_ff   <= red_ff;
         rsp_green_ff <= green_ff;
         rsp_blue_ff  <= blue_ff;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.out_position = rsp_pos_ff;
   assign rsp_chan.red          = rsp_red_ff;
   assign rsp_chan.green        = rsp_green_ff;
   assign rsp_chan.blue         = rsp_blue_ff;

   `LECR_ASSERT_NEXT(a_render_blocks, render_start, !req_chan.ready)
   `LECR_ASSERT_NEXT(a_travel_no_stall, req_fire && !req_chan.func, req_chan.ready)
   `LECR_ASSERT_NEXT(a_dark_is_direct, render_start && !lights_ff, ctrl.done)
   `LECR_ASSERT_IMP(a_load_only_done, out_load, !ctrl.idle)

endmodule
`default_nettype wire

// ===== sim/led_effect_color_renderer_tb.sv =====
`timescale 1ns / 1ps
module led_effect_color_renderer_tb;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 20;
   localparam int RANDOM_PHASES  = 12;
   localparam int RANDOM_ITEMS   = 720;
   localparam int HOLD_OFF       = 300;

   localparam logic       FUNC_TRAVEL = 1'b0;
   localparam logic       FUNC_RENDER = 1'b1;
   localparam logic [2:0] MODE_STATIC = 3'd0;
   localparam logic [2:0] DIR_EAST    = 3'd0;
   localparam logic [2:0] DIR_NORTH   = 3'd2;

   typedef struct packed {
      logic        lights;
      logic [2:0]  mode;
      logic [2:0]  direction;
      logic [7:0]  speed;
      logic [23:0] primary;
      logic [23:0] secondary;
      logic [23:0] reactive;
   } lighting_scene_type;

   typedef struct packed {
      logic        func;
      logic        first_key;
      logic [7:0]  key_travel;
      logic [6:0]  led_position;
      logic        led_present;
      logic [31:0] elapsed_ms;
   } led_request_type;

   typedef struct packed {
      logic [6:0]  position;
      logic [23:0] rgb;
   } led_color_type;

   localparam int REQ_BITS = $bits(led_request_type);

   logic                             clock;
   logic                             reset;
   logic                             csr_we;
   logic [lecr_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [lecr_pkg::CSR_DATA_W-1:0]  csr_wdata;

   lecr_req_if req_chan ();
   lecr_rsp_if rsp_chan ();

   led_effect_color_renderer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   lighting_scene_type scene;
   logic [7:0]         key_peak;
   led_color_type      colors_due[$];
   int                 error_count;
   bit                 idle_on;
   int                 rsp_hold_cycles;

   always #4 clock = ~clock;

   // ---------------- color prediction ----------------

   function automatic logic [7:0] mix_lane(logic [7:0] a, logic [7:0] b, logic [7:0] w);
      int unsigned sum;
      sum = a * (255 - w) + b * w + 127;
      return 8'(sum / 255);
   endfunction

   function automatic logic [23:0] blend_rgb(logic [23:0] a, logic [23:0] b, logic [7:0] w);
      return {mix_lane(a[23:16], b[23:16], w),
              mix_lane(a[15:8], b[15:8], w),
              mix_lane(a[7:0], b[7:0], w)};
   endfunction

   function automatic logic [7:0] sweep_position_weight(logic [6:0] pos);
      int unsigned n;
      n = pos * 255 / (lecr_pkg::POSITION_COUNT - 1);
      if (n > 255) n = 255;
      if (scene.direction == lecr_pkg::DIR_WEST || scene.direction == lecr_pkg::DIR_SOUTH) begin
         n = 255 - n;
      end else if (scene.direction == lecr_pkg::DIR_RADIAL) begin
         n = (n <= 127) ? n * 2 : (255 - n) * 2;
      end
      return 8'(n);
   endfunction

   function automatic logic [7:0] triangle_weight(int unsigned phase);
      phase = phase % 510;
      return 8'((phase <= 255) ? phase : 510 - phase);
   endfunction

   function automatic logic [23:0] expected_rgb(led_request_type r);
      logic [31:0] scaled;
      int unsigned phase;
      int unsigned heat;
      if (!scene.lights || !r.led_present) return 24'h0;
      case (scene.mode)
         lecr_pkg::MODE_GRADIENT: begin
            return blend_rgb(scene.primary, scene.secondary,
                             sweep_position_weight(r.led_position));
         end
         lecr_pkg::MODE_AURORA: begin
            // 32-bit wrap of ms * rate is intended
            scaled = r.elapsed_ms * (32'(scene.speed) + 32'd1);
            phase = scaled / 20 + 2 * sweep_position_weight(r.led_position);
            return blend_rgb(scene.primary, scene.secondary, triangle_weight(phase));
         end
         lecr_pkg::MODE_REACTIVE: begin
            return (key_peak == 8'd0) ? scene.primary : scene.reactive;
         end
         lecr_pkg::MODE_HEATMAP: begin
            heat = key_peak * 255 / lecr_pkg::TRAVEL_LIMIT;
            if (heat > 255) heat = 255;
            return blend_rgb(scene.primary, scene.reactive, 8'(heat));
         end
         default: begin
            return scene.primary;
         end
      endcase
   endfunction

   function automatic void track_request(led_request_type r);
      logic [7:0]    travel;
      led_color_type due;
      if (r.func == FUNC_TRAVEL) begin
         travel = (r.key_travel > lecr_pkg::TRAVEL_LIMIT) ? lecr_pkg::TRAVEL_MAX
                                                          : r.key_travel;
         if (r.first_key || travel > key_peak) key_peak = travel;
      end else begin
         due.position = r.led_position;
         due.rgb      = expected_rgb(r);
         colors_due.push_back(due);
      end
   endfunction

   // ---------------- stimulus helpers ----------------

   function automatic int pick_gap();
      return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
   endfunction

   function automatic logic [23:0] random_color();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return 24'h000000;
      if (pick == 1) return 24'hFFFFFF;
      return 24'($urandom);
   endfunction

   function automatic logic [7:0] random_travel();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return 8'd0;
      if (pick == 1) return 8'd255;
      return 8'($urandom);
   endfunction

   function automatic logic [31:0] random_ms();
      int pick;
      pick = $urandom_range(0, 3);
      if (pick == 0) return 32'($urandom_range(0, 2000));
      if (pick == 1) return 32'hFFFF_FFFF - 32'($urandom_range(0, 1000));
      return 32'($urandom);
   endfunction

   function automatic led_request_type random_request();
      return led_request_type'(REQ_BITS'({$urandom, $urandom}));
   endfunction

   // unused fields carry random bits to show they are ignored
   function automatic led_request_type travel_req(logic first, logic [7:0] travel);
      led_request_type r;
      r = random_request();
      r.func       = FUNC_TRAVEL;
      r.first_key  = first;
      r.key_travel = travel;
      return r;
   endfunction

   function automatic led_request_type render_req(logic [6:0] pos, logic present,
                                                  logic [31:0] ms);
      led_request_type r;
      r = random_request();
      r.func         = FUNC_RENDER;
      r.led_position = pos;
      r.led_present  = present;
      r.elapsed_ms   = ms;
      return r;
   endfunction

   function automatic lighting_scene_type random_scene(int phase);
      lighting_scene_type s;
      if (phase == 0) return '{1'b1, 3'd7, 3'd7, 8'd255, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF};
      if (phase == 1) return '{1'b1, MODE_STATIC, DIR_EAST, 8'd0, 24'h0, 24'h0, 24'h0};
      s.lights    = ($urandom_range(0, 9) != 0);
      s.mode      = ($urandom_range(0, 3) != 0) ? 3'($urandom_range(1, 4)) : 3'($urandom);
      s.direction = 3'($urandom);
      s.speed     = ($urandom_range(0, 4) == 0) ? 8'd255 : 8'($urandom);
      s.primary   = random_color();
      s.secondary = random_color();
      s.reactive  = random_color();
      return s;
   endfunction

   task automatic report_error(string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      error_count++;
   endtask

   task automatic write_reg(lecr_pkg::csr_index_type idx,
                            logic [lecr_pkg::CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic load_scene(lighting_scene_type s);
      write_reg(lecr_pkg::CSR_LIGHTS, lecr_pkg::CSR_DATA_W'(s.lights));
      write_reg(lecr_pkg::CSR_MODE, lecr_pkg::CSR_DATA_W'(s.mode));
      write_reg(lecr_pkg::CSR_DIR, lecr_pkg::CSR_DATA_W'(s.direction));
      write_reg(lecr_pkg::CSR_SPEED, lecr_pkg::CSR_DATA_W'(s.speed));
      write_reg(lecr_pkg::CSR_PRIMARY, s.primary);
      write_reg(lecr_pkg::CSR_SECONDARY, s.secondary);
      write_reg(lecr_pkg::CSR_REACTIVE, s.reactive);
      csr_we <= 1'b0;
      scene = s;
   endtask

   // called just after a rising edge; returns at the accepting edge or after a gap
   task automatic send_request(led_request_type r);
      int gap;
      req_chan.valid        <= 1'b1;
      req_chan.func         <= r.func;
      req_chan.first_key    <= r.first_key;
      req_chan.key_travel   <= r.key_travel;
      req_chan.led_position <= r.led_position;
      req_chan.led_present  <= r.led_present;
      req_chan.elapsed_ms   <= r.elapsed_ms;
      do @(posedge clock); while (!req_chan.ready);
      track_request(r);
      if (idle_on && $urandom_range(0, 99) < 30) begin
         gap = pick_gap();
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // sender pause: drain all colors, then let a trailing travel request settle
   task automatic wait_for_colors();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (colors_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------- tests ----------------

   task automatic test_reset_state();
      send_request(render_req(7'd127, 1'b1, 32'($urandom)));
      send_request(travel_req(1'b0, 8'd200));
      wait_for_colors();
   endtask

   task automatic test_static_and_absent();
      load_scene('{1'b1, MODE_STATIC, DIR_EAST, 8'd0, 24'hFFFFFF, 24'h0, 24'h0});
      send_request(render_req(7'd0, 1'b0, 32'd0));
      send_request(render_req(7'd127, 1'b1, 32'hFFFF_FFFF));
      wait_for_colors();
   endtask

   task automatic test_gradient_radial();
      load_scene('{1'b1, lecr_pkg::MODE_GRADIENT, lecr_pkg::DIR_RADIAL, 8'd0,
                   24'h000000, 24'hFFFFFF, 24'h0});
      send_request(render_req(7'd0, 1'b1, 32'd0));
      send_request(render_req(7'd63, 1'b1, 32'd0));
      send_request(render_req(7'd64, 1'b1, 32'd0));
      send_request(render_req(7'd127, 1'b1, 32'd0));
      wait_for_colors();
   endtask

   task automatic test_aurora_wrap();
      load_scene('{1'b1, lecr_pkg::MODE_AURORA, lecr_pkg::DIR_WEST, 8'd255,
                   24'hFF00FF, 24'h00FF00, 24'h0});
      send_request(render_req(7'd0, 1'b1, 32'hFFFF_FFFF));
      send_request(render_req(7'd127, 1'b1, 32'd0));
      send_request(render_req(7'd40, 1'b1, 32'd12345));
      wait_for_colors();
   endtask

   task automatic test_reactive_peak();
      load_scene('{1'b1, lecr_pkg::MODE_REACTIVE, lecr_pkg::DIR_SOUTH, 8'd1,
                   24'h123456, 24'h0, 24'hABCDEF});
      send_request(travel_req(1'b1, 8'd0));
      send_request(render_req(7'd5, 1'b1, 32'd0));
      send_request(travel_req(1'b0, 8'd255));
      send_request(render_req(7'd6, 1'b1, 32'd0));
      wait_for_colors();
   endtask

   task automatic test_heatmap_peak();
      load_scene('{1'b1, lecr_pkg::MODE_HEATMAP, DIR_NORTH, 8'd0,
                   24'h000000, 24'h0, 24'hFFFFFF});
      send_request(travel_req(1'b1, 8'd128));
      send_request(render_req(7'd10, 1'b1, 32'd0));
      // lower reading without restart keeps the peak
      send_request(travel_req(1'b0, 8'd10));
      send_request(render_req(7'd11, 1'b1, 32'd0));
      send_request(travel_req(1'b1, 8'd255));
      send_request(render_req(7'd12, 1'b1, 32'd0));
      wait_for_colors();
   endtask

   task automatic test_unknown_codes();
      load_scene('{1'b1, 3'd7, 3'd7, 8'd255, 24'hA5C3E1, 24'hFFFFFF, 24'hFFFFFF});
      send_request(render_req(7'd99, 1'b1, 32'($urandom)));
      wait_for_colors();
   endtask

   // frames: a burst of key samples, then a run of positions; at times a single random request
   task automatic test_random_frames();
      int sent;
      int keys;
      int renders;
      int k;
      int i;
      logic [6:0]  base;
      logic [31:0] ms;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         load_scene(random_scene(p));
         idle_on = (p % 4 != 1);
         sent = 0;
         while (sent < RANDOM_ITEMS / RANDOM_PHASES) begin
            if ($urandom_range(0, 9) == 0) begin
               send_request(random_request());
               sent++;
            end else begin
               keys = $urandom_range(0, 5);
               for (k = 0; k < keys; k++) begin
                  send_request(travel_req(k == 0 || $urandom_range(0, 15) == 0,
                                          random_travel()));
               end
               base    = ($urandom_range(0, 9) == 0) ? 7'd120 : 7'($urandom);
               renders = $urandom_range(3, 10);
               ms      = random_ms();
               for (i = 0; i < renders; i++) begin
                  send_request(render_req(7'(base + i), $urandom_range(0, 6) != 0, ms));
               end
               sent += keys + renders;
            end
         end
         wait_for_colors();
      end
      idle_on = 1'b1;
   endtask

   // receiver holds off while the sender keeps offering, so the input stalls
   task automatic test_output_backpressure();
      load_scene('{1'b1, lecr_pkg::MODE_AURORA, lecr_pkg::DIR_RADIAL, 8'd37,
                   24'h102030, 24'hF0E0D0, 24'h0});
      idle_on = 1'b0;
      rsp_hold_cycles = HOLD_OFF;
      for (int i = 0; i < 20; i++) begin
         send_request(render_req(7'(i * 6), 1'b1, random_ms()));
      end
      wait_for_colors();
      idle_on = 1'b1;
   endtask

   // ---------------- result side ----------------

   initial begin : color_sink
      int stall;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
            rsp_chan.ready <= 1'b1;
         end else if (idle_on && $urandom_range(0, 99) < 25) begin
            stall = pick_gap();
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
            rsp_chan.ready <= 1'b1;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      led_color_type due;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (colors_due.size() == 0) begin
            report_error($sformatf("color for position %0d with none pending",
                                   rsp_chan.out_position));
         end else begin
            due = colors_due.pop_front();
            if (rsp_chan.out_position !== due.position)
               report_error($sformatf("position: expected %0d got %0d",
                                      due.position, rsp_chan.out_position));
            if (rsp_chan.red !== due.rgb[23:16])
               report_error($sformatf("red at %0d: expected %02h got %02h",
                                      due.position, due.rgb[23:16], rsp_chan.red));
            if (rsp_chan.green !== due.rgb[15:8])
               report_error($sformatf("green at %0d: expected %02h got %02h",
                                      due.position, due.rgb[15:8], rsp_chan.green));
            if (rsp_chan.blue !== due.rgb[7:0])
               report_error($sformatf("blue at %0d: expected %02h got %02h",
                                      due.position, due.rgb[7:0], rsp_chan.blue));
         end
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_chan.valid && req_chan.ready) ||
             (rsp_chan.valid && rsp_chan.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      clock                 = 1'b0;
      reset                 = 1'b1;
      csr_we                = 1'b0;
      csr_index             = '0;
      csr_wdata             = '0;
      req_chan.valid        = 1'b0;
      req_chan.func         = FUNC_TRAVEL;
      req_chan.first_key    = 1'b0;
      req_chan.key_travel   = '0;
      req_chan.led_position = '0;
      req_chan.led_present  = 1'b0;
      req_chan.elapsed_ms   = '0;
      scene                 = '0;
      key_peak              = '0;
      error_count           = 0;
      idle_on               = 1'b1;
      rsp_hold_cycles       = 0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_static_and_absent();
      test_gradient_radial();
      test_aurora_wrap();
      test_reactive_peak();
      test_heatmap_peak();
      test_unknown_codes();
      test_output_backpressure();
      test_random_frames();

      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
